// File: rtl/ept_pkg.sv
package ept_pkg;

    localparam int CAP_W   = 24;
    localparam int SCALE_W = 32;

    // configuration register indexes
    localparam logic REG_NOISE_THRESHOLD = 1'b0;
    localparam logic REG_SPEED_SCALE     = 1'b1;

    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic             action;
        logic [CAP_W-1:0] capture_time;
    } ept_in_t;

    typedef struct packed {
        logic [SCALE_W-1:0] speed;
        logic [CAP_W-1:0]   avg_period;
        logic               stalled;
    } ept_out_t;

endpackage

// File: rtl/ept_div.sv
module ept_div #(
    parameter int N_W = 32,
    parameter int D_W = 24
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           busy,
    output logic           done,
    output logic [N_W-1:0] quotient
);
    import ept_pkg::*;

    localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic [N_W-1:0]   num_reg, num_next;
    logic [D_W-1:0]   den_reg, den_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [D_W:0]     trial;
    logic [D_W:0]     trial_sub;
    logic             q_bit;

    // one quotient bit per cycle, dividend bits shift out msb first
    always_comb
    begin
        trial     = {rem_reg, num_reg[N_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        q_bit     = !trial_sub[D_W];

        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (busy_reg)
        begin
            num_next = {num_reg[N_W-2:0], q_bit};
            rem_next = q_bit ? trial_sub[D_W-1:0] : trial[D_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// File: rtl/edge_period_tachometer_core.sv
// channel  | handshake                 | payload
// item     | item_valid / item_stall   | item   (action, capture_time)
// result   | result_valid / result_stall | result (speed, avg_period, stalled)
// config   | cfg_we                    | cfg_index, cfg_data
//
// an edge item is handled as wrapped difference, then threshold check and sum
// a tick item divides on the shared
// bit-serial divider when there is data (one quotient bit per cycle, average then speed)
// items are taken only while idle; a finished result sits in the output register
// reset clears captures, sum, count, held period and the registers to defaults
module edge_period_tachometer_core #(
    parameter int MAX_PERIODS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  ept_pkg::ept_in_t item,
    output logic             result_valid,
    input  logic             result_stall,
    output ept_pkg::ept_out_t result,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_data
);
    import ept_pkg::*;

    localparam int CNT_W   = $clog2(MAX_PERIODS + 1);
    localparam int SUM_W   = CAP_W + CNT_W;
    localparam int DIV_N_W = (SUM_W > SCALE_W) ? SUM_W : SCALE_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_ACC     = 3'd1;
    localparam logic [2:0] ST_DIV_AVG = 3'd2;
    localparam logic [2:0] ST_DIV_SPD = 3'd3;
    localparam logic [2:0] ST_FIN     = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [CAP_W-1:0]   thr_reg, thr_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [CAP_W-1:0]   latest_reg, latest_next;
    logic [CAP_W-1:0]   at_tick_reg, at_tick_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CAP_W-1:0]   held_reg, held_next;
    logic [CAP_W-1:0]   diff_reg, diff_next;
    logic               edge_ok_reg, edge_ok_next;
    logic [SCALE_W-1:0] res_speed_reg, res_speed_next;
    logic               res_stalled_reg, res_stalled_next;
    logic               result_valid_reg, result_valid_next;
    ept_out_t           result_reg, result_next;

    logic               div_start;
    logic [DIV_N_W-1:0] div_dividend;
    logic [CAP_W-1:0]   div_divisor;
    logic               div_busy;
    logic               div_done;
    logic [DIV_N_W-1:0] div_quot;
    logic               item_take;

    ept_div #(
        .N_W (DIV_N_W),
        .D_W (CAP_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign item_stall = (state_reg != ST_IDLE);
    assign item_take  = item_valid && !item_stall;

    always_comb
    begin
        state_next        = state_reg;
        thr_next          = thr_reg;
        scale_next        = scale_reg;
        latest_next       = latest_reg;
        at_tick_next      = at_tick_reg;
        sum_next          = sum_reg;
        count_next        = count_reg;
        held_next         = held_reg;
        diff_next         = diff_reg;
        edge_ok_next      = edge_ok_reg;
        res_speed_next    = res_speed_reg;
        res_stalled_next  = res_stalled_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        div_start         = 1'b0;
        div_dividend      = DIV_N_W'(scale_reg);
        div_divisor       = held_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_NOISE_THRESHOLD: thr_next   = cfg_data[CAP_W-1:0];
                REG_SPEED_SCALE:     scale_next = cfg_data[SCALE_W-1:0];
                default:             thr_next   = thr_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    if (item.action == ACT_EDGE)
                    begin
                        diff_next    = latest_reg - item.capture_time;
                        edge_ok_next = (latest_reg != '0);
                        latest_next  = item.capture_time;
                        state_next   = ST_ACC;
                    end
                    else if (latest_reg == at_tick_reg)
                    begin
                        // no edge since the previous tick
                        latest_next      = '0;
                        at_tick_next     = '0;
                        held_next        = '0;
                        res_speed_next   = '0;
                        res_stalled_next = 1'b1;
                        state_next       = ST_FIN;
                    end
                    else
                    begin
                        at_tick_next     = latest_reg;
                        res_stalled_next = 1'b0;
                        res_speed_next   = '0;
                        if (count_reg != '0)
                        begin
                            div_start    = 1'b1;
                            div_dividend = DIV_N_W'(sum_reg);
                            div_divisor  = CAP_W'(count_reg);
                            state_next   = ST_DIV_AVG;
                        end
                        else if (held_reg != '0)
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV_SPD;
                        end
                        else
                        begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end

            ST_ACC:
            begin
                if (edge_ok_reg && (diff_reg > thr_reg)
                    && (count_reg < CNT_W'(MAX_PERIODS)))
                begin
                    sum_next   = sum_reg + SUM_W'(diff_reg);
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end

            ST_DIV_AVG:
            begin
                if (div_done)
                begin
                    held_next  = div_quot[CAP_W-1:0];
                    sum_next   = '0;
                    count_next = '0;
                    if (div_quot[CAP_W-1:0] != '0)
                    begin
                        div_start   = 1'b1;
                        div_divisor = div_quot[CAP_W-1:0];
                        state_next  = ST_DIV_SPD;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_DIV_SPD:
            begin
                if (div_done)
                begin
                    res_speed_next = div_quot[SCALE_W-1:0];
                    state_next     = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next      = 1'b1;
                    result_next.speed      = res_speed_reg;
                    result_next.avg_period = held_reg;
                    result_next.stalled    = res_stalled_reg;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            thr_reg          <= CAP_W'(66400);
            scale_reg        <= SCALE_W'(204800000);
            latest_reg       <= '0;
            at_tick_reg      <= '0;
            sum_reg          <= '0;
            count_reg        <= '0;
            held_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            thr_reg          <= thr_next;
            scale_reg        <= scale_next;
            latest_reg       <= latest_next;
            at_tick_reg      <= at_tick_next;
            sum_reg          <= sum_next;
            count_reg        <= count_next;
            held_reg         <= held_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg        <= diff_next;
        edge_ok_reg     <= edge_ok_next;
        res_speed_reg   <= res_speed_next;
        res_stalled_reg <= res_stalled_next;
        result_reg      <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PERIODS))
        else $error("period count above limit");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_AVG || state_reg == ST_DIV_SPD))
        else $error("divider finished outside a divide state");

    a_stall_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.stalled |-> result.speed == '0 && result.avg_period == '0)
        else $error("stalled result with nonzero fields");

endmodule
